[hw/rtl/kar_pkg.sv]
// kar_pkg: shared widths, item kind codes, the per-key table entry type and the
// divider result type for the key edge and auto-repeat block; no dependencies
package kar_pkg;

    localparam int NUM_KEYS     = 16;
    localparam int KEY_W        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_INDEX_W  = 4;
    localparam int KIND_W       = 2;
    localparam int TICK_W       = 20;
    localparam int PERIOD_W     = 24;
    localparam int ELAPSED_W    = 25;
    localparam int DIV_CNT_W    = $clog2(ELAPSED_W + 1);

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PERIOD = 2'd2;

    typedef struct packed {
        logic                 down;
        logic                 pressed;
        logic                 released;
        logic                 repeat_on;
        logic [ELAPSED_W-1:0] elapsed;
        logic [PERIOD_W-1:0]  period;
    } key_entry_t;

    typedef struct packed {
        logic                odd;
        logic                nonzero;
        logic [PERIOD_W-1:0] remainder;
    } div_res_t;

endpackage

[hw/rtl/key_edge_and_auto_repeat.sv]
// key_edge_and_auto_repeat: per-key edge flags and typematic repeat over a
// key table held in a synchronous memory; uses kar_pkg and kar_div
//
//   channel   signals                                            dir
//   input     in_valid/in_ready, kind, key_index, level,         in
//             tick_delta, period_value
//   output    out_valid/out_ready, key_number, down_flag,        out
//             pressed_flag, released_flag, repeating, last
//
// each item sweeps all NUM_KEYS table entries: each entry is read in ST_DATA,
// then written back and reported in ST_EMIT
// on a tick, each repeating key with a nonzero period also waits in ST_DIV
// for the serial divider
// reset clears per-entry valid bits at once; no clearing pass is needed
// a stalled output holds the sweep; a new item is taken while the last
// result still waits
module key_edge_and_auto_repeat (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [kar_pkg::KIND_W-1:0]      kind,
    input  logic [kar_pkg::KEY_INDEX_W-1:0] key_index,
    input  logic                            level,
    input  logic [kar_pkg::TICK_W-1:0]      tick_delta,
    input  logic [kar_pkg::PERIOD_W-1:0]    period_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [kar_pkg::KEY_INDEX_W-1:0] key_number,
    output logic                            down_flag,
    output logic                            pressed_flag,
    output logic                            released_flag,
    output logic                            repeating,
    output logic                            last
);
    import kar_pkg::*;

    localparam int CMP_W = (KEY_W > KEY_INDEX_W) ? KEY_W : KEY_INDEX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DATA = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // key table
    key_entry_t           mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]  entry_valid_reg;
    key_entry_t           rd_data_reg;
    logic                 rd_valid_reg;
    logic                 rd_en;
    logic [KEY_W-1:0]     rd_addr;
    logic                 mem_we;

    logic [1:0]             state_reg, state_next;
    logic [KEY_W-1:0]       k_reg, k_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [KEY_INDEX_W-1:0] key_reg;
    logic                   level_reg;
    logic [TICK_W-1:0]      delta_reg;
    logic [PERIOD_W-1:0]    period_reg;

    logic                   out_valid_reg;
    logic [KEY_INDEX_W-1:0] key_number_reg;
    logic                   down_reg;
    logic                   pressed_reg;
    logic                   released_reg;
    logic                   repeating_reg;
    logic                   last_reg;

    key_entry_t           cur;
    key_entry_t           upd;
    logic [ELAPSED_W-1:0] tick_sum;
    logic                 hit;
    logic                 is_last;
    logic                 out_free;
    logic                 load;
    logic                 div_start;
    logic                 div_busy;
    div_res_t             div_res;

    kar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tick_sum),
        .divisor  (cur.period),
        .busy     (div_busy),
        .result   (div_res)
    );

    assign cur      = rd_valid_reg ? rd_data_reg : '0;
    assign tick_sum = cur.elapsed + ELAPSED_W'(delta_reg);
    assign hit      = (CMP_W'(k_reg) == CMP_W'(key_reg));
    assign is_last  = (k_reg == KEY_W'(NUM_KEYS - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign div_start = (state_reg == ST_DATA) && (kind_reg == KIND_TICK)
                       && cur.repeat_on && (cur.period != '0);
    assign load      = (state_reg == ST_EMIT) && out_free;
    assign mem_we    = load;

    // new entry for the key under the sweep
    always_comb
    begin
        upd = cur;
        case (kind_reg)
            KIND_SAMPLE:
            begin
                if (hit)
                begin
                    if (!cur.repeat_on)
                    begin
                        upd.down     = level_reg;
                        upd.pressed  = !cur.down && level_reg;
                        upd.released = cur.down && !level_reg;
                        if (!cur.down && level_reg && (cur.period != '0))
                        begin
                            upd.repeat_on = 1'b1;
                            upd.elapsed   = '0;
                        end
                    end
                    else if (!level_reg)
                    begin
                        upd.down      = 1'b0;
                        upd.pressed   = 1'b0;
                        upd.released  = cur.down;
                        upd.repeat_on = 1'b0;
                    end
                end
            end
            KIND_TICK:
            begin
                if (cur.repeat_on)
                begin
                    upd.pressed  = 1'b0;
                    upd.released = 1'b0;
                    upd.elapsed  = tick_sum;
                    if (cur.period != '0)
                    begin
                        upd.elapsed = ELAPSED_W'(div_res.remainder);
                        if (div_res.nonzero)
                        begin
                            upd.down     = cur.down ^ div_res.odd;
                            upd.pressed  = cur.down ^ div_res.odd;
                            upd.released = !(cur.down ^ div_res.odd);
                        end
                    end
                end
            end
            KIND_PERIOD:
            begin
                if (hit)
                begin
                    upd        = '0;
                    upd.period = period_reg;
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        rd_en      = 1'b0;
        rd_addr    = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    k_next     = '0;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                state_next = div_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = k_reg + 1'b1;
                        state_next = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (mem_we)
            begin
                entry_valid_reg[k_reg] <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[k_reg] <= upd;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            key_reg    <= key_index;
            level_reg  <= level;
            delta_reg  <= tick_delta;
            period_reg <= period_value;
        end
        if (load)
        begin
            key_number_reg <= KEY_INDEX_W'(k_reg);
            down_reg       <= upd.down;
            pressed_reg    <= upd.pressed;
            released_reg   <= upd.released;
            repeating_reg  <= upd.repeat_on;
            last_reg       <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_number    = key_number_reg;
    assign down_flag     = down_reg;
    assign pressed_flag  = pressed_reg;
    assign released_flag = released_reg;
    assign repeating     = repeating_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while no item is in progress");

    a_div_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (kind_reg == KIND_TICK) && cur.repeat_on)
        else $error("divider started outside a tick on a repeating key");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("final result did not close the item");

    a_write_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (!out_valid_reg || out_ready))
        else $error("table written back while the result slot is full");

    a_sweep_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_last) |=> (k_reg == $past(k_reg) + 1'b1) && (state_reg == ST_DATA))
        else $error("key sweep skipped or repeated an entry");
`endif

endmodule

[hw/rtl/kar_div.sv]
// kar_div: restoring divider, one quotient bit per cycle, giving the
// remainder and the parity and nonzero state of the quotient; uses kar_pkg
module kar_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [kar_pkg::ELAPSED_W-1:0]  dividend,
    input  logic [kar_pkg::PERIOD_W-1:0]   divisor,
    output logic                           busy,
    output kar_pkg::div_res_t              result
);
    import kar_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ELAPSED_W-1:0] dvd_reg;
    logic [PERIOD_W-1:0]  dsr_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic                 odd_reg;
    logic                 nz_reg;

    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W:0]    diff;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[ELAPSED_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(ELAPSED_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            odd_reg <= 1'b0;
            nz_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ELAPSED_W-2:0], 1'b0};
            rem_reg <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            odd_reg <= ge;
            nz_reg  <= nz_reg | ge;
        end
    end

    assign busy             = busy_reg;
    assign result.odd       = odd_reg;
    assign result.nonzero   = nz_reg;
    assign result.remainder = rem_reg;

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for key_edge_and_auto_repeat, with its own
// per-key flag and repeat-timer model, random handshake gaps and stalls
// depends on kar_pkg and the key_edge_and_auto_repeat rtl
module testbench;
    import kar_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 500;

    typedef struct {
        logic [KEY_INDEX_W-1:0] number;
        logic                   down;
        logic                   pressed;
        logic                   released;
        logic                   repeating;
        logic                   last;
    } key_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind;
    logic [KEY_INDEX_W-1:0] key_index;
    logic                   level;
    logic [TICK_W-1:0]      tick_delta;
    logic [PERIOD_W-1:0]    period_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [KEY_INDEX_W-1:0] key_number;
    logic                   down_flag;
    logic                   pressed_flag;
    logic                   released_flag;
    logic                   repeating;
    logic                   last;

    // model of the key table
    logic                 key_down      [NUM_KEYS];
    logic                 key_pressed   [NUM_KEYS];
    logic                 key_released  [NUM_KEYS];
    logic                 key_repeating [NUM_KEYS];
    logic [ELAPSED_W-1:0] key_elapsed   [NUM_KEYS];
    logic [PERIOD_W-1:0]  key_period    [NUM_KEYS];

    key_report_t expected_reports[$];
    bit          failed;
    bit          bursty;
    int          items_sent;
    int          cycles;

    key_edge_and_auto_repeat uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .key_index     (key_index),
        .level         (level),
        .tick_delta    (tick_delta),
        .period_value  (period_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_number    (key_number),
        .down_flag     (down_flag),
        .pressed_flag  (pressed_flag),
        .released_flag (released_flag),
        .repeating     (repeating),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (bursty || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r < 12)
            return PERIOD_W'($urandom_range(1, 2000));
        if (r < 16)
            return PERIOD_W'($urandom_range(1, 20'hFFFFF));
        if (r < 19)
            return PERIOD_W'($urandom);
        return {PERIOD_W{1'b1}};
    endfunction

    // delta mostly scaled to the key's period so that zero, one and several
    // whole periods all occur
    function automatic logic [TICK_W-1:0] pick_delta(logic [PERIOD_W-1:0] per);
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return {TICK_W{1'b1}};
        if (r < 4)
            return TICK_W'($urandom);
        top = (per == 0 || per > 24'h55555) ? 20'hFFFFF : per * 3;
        return TICK_W'($urandom_range(0, top));
    endfunction

    task automatic apply_key_item(input logic [KIND_W-1:0] kind_i,
                                  input logic [KEY_INDEX_W-1:0] key_i,
                                  input logic level_i,
                                  input logic [TICK_W-1:0] delta_i,
                                  input logic [PERIOD_W-1:0] per_i);
        logic                 was;
        logic [ELAPSED_W-1:0] sum;
        logic [ELAPSED_W-1:0] wholes;
        key_report_t          rep;
        int                   k;
        if (kind_i == KIND_SAMPLE)
        begin
            was = key_down[key_i];
            if (!key_repeating[key_i])
            begin
                key_down[key_i] = level_i;
                key_pressed[key_i] = !was && level_i;
                key_released[key_i] = was && !level_i;
                if (key_pressed[key_i] && key_period[key_i] != 0)
                begin
                    key_repeating[key_i] = 1'b1;
                    key_elapsed[key_i] = '0;
                end
            end
            else if (!level_i)
            begin
                key_down[key_i] = 1'b0;
                key_pressed[key_i] = 1'b0;
                key_released[key_i] = was;
                key_repeating[key_i] = 1'b0;
            end
        end
        else if (kind_i == KIND_TICK)
        begin
            for (k = 0; k < NUM_KEYS; k++)
            begin
                if (key_repeating[k])
                begin
                    key_pressed[k] = 1'b0;
                    key_released[k] = 1'b0;
                    sum = key_elapsed[k] + ELAPSED_W'(delta_i);
                    key_elapsed[k] = sum;
                    if (key_period[k] != 0)
                    begin
                        wholes = sum / key_period[k];
                        key_elapsed[k] = sum % key_period[k];
                        if (wholes != 0)
                        begin
                            if (wholes[0])
                                key_down[k] = !key_down[k];
                            key_pressed[k] = key_down[k];
                            key_released[k] = !key_down[k];
                        end
                    end
                end
            end
        end
        else if (kind_i == KIND_PERIOD)
        begin
            key_down[key_i] = 1'b0;
            key_pressed[key_i] = 1'b0;
            key_released[key_i] = 1'b0;
            key_repeating[key_i] = 1'b0;
            key_elapsed[key_i] = '0;
            key_period[key_i] = per_i;
        end
        for (k = 0; k < NUM_KEYS; k++)
        begin
            rep.number = KEY_INDEX_W'(k);
            rep.down = key_down[k];
            rep.pressed = key_pressed[k];
            rep.released = key_released[k];
            rep.repeating = key_repeating[k];
            rep.last = (k == NUM_KEYS - 1);
            expected_reports.push_back(rep);
        end
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind_i,
                             input logic [KEY_INDEX_W-1:0] key_i,
                             input logic level_i,
                             input logic [TICK_W-1:0] delta_i,
                             input logic [PERIOD_W-1:0] per_i);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= kind_i;
        key_index <= key_i;
        level <= level_i;
        tick_delta <= delta_i;
        period_value <= per_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_key_item(kind_i, key_i, level_i, delta_i, per_i);
        items_sent++;
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // result checker
    initial
    begin
        key_report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result for key %0d", key_number);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("key_number", want.number, key_number);
                    check_field("down_flag", 4'(want.down), 4'(down_flag));
                    check_field("pressed_flag", 4'(want.pressed), 4'(pressed_flag));
                    check_field("released_flag", 4'(want.released), 4'(released_flag));
                    check_field("repeating", 4'(want.repeating), 4'(repeating));
                    check_field("last", 4'(want.last), 4'(last));
                end
            end
        end
    end

    // receiver stalls, with quiet stretches of no stalling
    initial
    begin
        int stall_left;
        int phase_left;
        bit quiet;
        stall_left = 0;
        phase_left = 0;
        quiet = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                          : $urandom_range(0, 2);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_edge_flags();
        send_item(KIND_SAMPLE, 4'd0, 1'b1, '0, '0);
        send_item(KIND_SAMPLE, 4'd0, 1'b1, '1, '1);
        send_item(KIND_SAMPLE, 4'd0, 1'b0, '0, '0);
        send_item(KIND_SAMPLE, 4'd0, 1'b0, '1, '1);
        send_item(KIND_SAMPLE, 4'd15, 1'b1, '0, '0);
        send_item(KIND_PERIOD, 4'd15, 1'b1, '1, {PERIOD_W{1'b1}});
    endtask

    task automatic test_repeat_timing();
        send_item(KIND_PERIOD, 4'd3, 1'b0, '0, 24'd100);
        send_item(KIND_SAMPLE, 4'd3, 1'b1, '0, '0);
        // held while repeating
        send_item(KIND_SAMPLE, 4'd3, 1'b1, '0, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, 20'd0, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, 20'd99, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, 20'd1, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, 20'd250, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, {TICK_W{1'b1}}, '0);
        send_item(KIND_PERIOD, 4'd9, 1'b0, '0, 24'd1);
        send_item(KIND_SAMPLE, 4'd9, 1'b1, '0, '0);
        send_item(KIND_TICK, 4'd0, 1'b0, 20'd3, '0);
        send_item(KIND_SAMPLE, 4'd15, 1'b1, '0, '0);
        send_item(KIND_TICK, 4'd15, 1'b1, {TICK_W{1'b1}}, '1);
        send_item(KIND_SAMPLE, 4'd3, 1'b0, '0, '0);
        send_item(KIND_PERIOD, 4'd15, 1'b0, '0, '0);
    endtask

    task automatic test_unused_kind();
        send_item(KIND_UNUSED, 4'd15, 1'b1, '1, '1);
        send_item(KIND_UNUSED, 4'd0, 1'b0, '0, '0);
    endtask

    // press, ticks and noise, then usually a release, on one key at a time
    task automatic test_random_traffic();
        logic [KEY_INDEX_W-1:0] k;
        int                     steps;
        while (items_sent < ITEM_TARGET)
        begin
            bursty = ($urandom_range(0, 3) == 0);
            k = KEY_INDEX_W'($urandom_range(0, NUM_KEYS - 1));
            if ($urandom_range(0, 3) != 0)
                send_item(KIND_PERIOD, k, 1'($urandom), TICK_W'($urandom), pick_period());
            send_item(KIND_SAMPLE, k, 1'b1, TICK_W'($urandom), PERIOD_W'($urandom));
            steps = $urandom_range(1, 8);
            repeat (steps)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        send_item(KIND_TICK, KEY_INDEX_W'($urandom), 1'($urandom),
                                  pick_delta(key_period[k]), PERIOD_W'($urandom));
                    6, 7:
                        send_item(KIND_SAMPLE, KEY_INDEX_W'($urandom), 1'($urandom),
                                  TICK_W'($urandom), PERIOD_W'($urandom));
                    8:
                        send_item(KIND_SAMPLE, k, 1'b1, TICK_W'($urandom),
                                  PERIOD_W'($urandom));
                    default:
                        if ($urandom_range(0, 1) == 0)
                            send_item(KIND_UNUSED, KEY_INDEX_W'($urandom), 1'($urandom),
                                      TICK_W'($urandom), PERIOD_W'($urandom));
                        else
                            send_item(KIND_PERIOD, KEY_INDEX_W'($urandom), 1'($urandom),
                                      TICK_W'($urandom), pick_period());
                endcase
            end
            if ($urandom_range(0, 4) != 0)
                send_item(KIND_SAMPLE, k, 1'b0, TICK_W'($urandom), PERIOD_W'($urandom));
        end
    endtask

    initial
    begin
        int k;
        failed = 1'b0;
        bursty = 1'b0;
        items_sent = 0;
        for (k = 0; k < NUM_KEYS; k++)
        begin
            key_down[k] = 1'b0;
            key_pressed[k] = 1'b0;
            key_released[k] = 1'b0;
            key_repeating[k] = 1'b0;
            key_elapsed[k] = '0;
            key_period[k] = '0;
        end
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_SAMPLE;
        key_index <= '0;
        level <= 1'b0;
        tick_delta <= '0;
        period_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_flags();
        test_repeat_timing();
        test_unused_kind();
        test_random_traffic();
        in_valid <= 1'b0;

        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d results never arrived", expected_reports.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
